/* sv/assert_macros.svh */
// concurrent assertion helpers, clocked on clk and disabled in reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// condition holds at every clock edge
`define RLE_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define RLE_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent holds in the cycle after the antecedent
`define RLE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define RLE_ASSERT(lbl, cond, msg)
`define RLE_ASSERT_IMPL(lbl, ante, cons, msg)
`define RLE_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

/* sv/rleg_pkg.sv */
`default_nettype none

package rleg_pkg;

	// field widths
	localparam int LEVEL_BITS = 16;
	localparam int TIME_BITS  = 24;
	localparam int SP_BITS    = 24;
	localparam int Q_BITS     = 32;
	localparam int LSHIFT     = 31 - LEVEL_BITS;
	localparam int PROD_BITS  = Q_BITS + SP_BITS;
	localparam int QUO_BITS   = 32;
	localparam int DIV_STEPS  = QUO_BITS;
	localparam int CNT_BITS   = $clog2(DIV_STEPS);

	// fixed-point constants
	localparam logic signed [Q_BITS-1:0] ONE_Q30 = Q_BITS'(1) << 30;
	localparam logic signed [LEVEL_BITS-1:0] GATE_HALF = LEVEL_BITS'(1) << (LEVEL_BITS - 2);
	localparam logic signed [LEVEL_BITS-1:0] LEVEL_MAXPOS =
		(LEVEL_BITS'(1) << (LEVEL_BITS - 1)) - LEVEL_BITS'(1);
	localparam logic [TIME_BITS-1:0] TIME_FLOOR = TIME_BITS'(7);

	// configuration register map
	localparam logic REG_LOOP_MODE     = 1'b0;
	localparam logic REG_SAMPLE_PERIOD = 1'b1;
	localparam logic [SP_BITS-1:0] SAMPLE_PERIOD_RESET = SP_BITS'(350);

	typedef enum logic [2:0] {
		STG_IDLE    = 3'd0,
		STG_SEG1    = 3'd1,
		STG_SEG2    = 3'd2,
		STG_SEG3    = 3'd3,
		STG_SUSTAIN = 3'd4,
		STG_RELEASE = 3'd5
	} stage_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_MUL,
		ST_SETUP,
		ST_DIV,
		ST_APPLY,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic signed [LEVEL_BITS-1:0] gate_level;
		logic signed [LEVEL_BITS-1:0] level_one;
		logic signed [LEVEL_BITS-1:0] level_two;
		logic signed [LEVEL_BITS-1:0] level_three;
		logic signed [LEVEL_BITS-1:0] level_four;
		logic [TIME_BITS-1:0]         time_one;
		logic [TIME_BITS-1:0]         time_two;
		logic [TIME_BITS-1:0]         time_three;
		logic [TIME_BITS-1:0]         time_four;
	} sample_t;

	typedef struct packed {
		logic signed [LEVEL_BITS-1:0] env_out;
		logic [2:0]                   stage_now;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic eval;
		logic mul;
		logic setup;
		logic div_step;
		logic apply;
		logic out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic run_div;
	} status_t;

endpackage

`default_nettype wire

/* sv/rleg_ctrl.sv */
`default_nettype none

module rleg_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               sample_valid,
	input  wire logic               result_stall,
	input  wire rleg_pkg::status_t  status,
	output rleg_pkg::cmd_t          cmd,
	output logic                    sample_stall,
	output logic                    result_valid
);

	rleg_pkg::state_t state_q, state_d;
	logic [rleg_pkg::CNT_BITS-1:0] cnt_q;
	logic valid_q;

	// state register, divide step counter, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rleg_pkg::ST_IDLE;
			cnt_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == rleg_pkg::ST_DIV) begin
				cnt_q <= cnt_q + rleg_pkg::CNT_BITS'(1);
			end else begin
				cnt_q <= '0;
			end
			if (cmd.out_load) begin
				valid_q <= 1'b1;
			end else if (!result_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	// next state and commands
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			rleg_pkg::ST_IDLE: begin
				if (sample_valid) begin
					cmd.load = 1'b1;
					state_d  = rleg_pkg::ST_EVAL;
				end
			end
			rleg_pkg::ST_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = status.run_div ? rleg_pkg::ST_MUL : rleg_pkg::ST_FINISH;
			end
			rleg_pkg::ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = rleg_pkg::ST_SETUP;
			end
			rleg_pkg::ST_SETUP: begin
				cmd.setup = 1'b1;
				state_d   = rleg_pkg::ST_DIV;
			end
			rleg_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == rleg_pkg::CNT_BITS'(rleg_pkg::DIV_STEPS - 1)) begin
					state_d = rleg_pkg::ST_APPLY;
				end
			end
			rleg_pkg::ST_APPLY: begin
				cmd.apply = 1'b1;
				state_d   = rleg_pkg::ST_FINISH;
			end
			rleg_pkg::ST_FINISH: begin
				// wait for the output register to free up
				if (!valid_q || !result_stall) begin
					cmd.out_load = 1'b1;
					state_d      = rleg_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rleg_pkg::ST_IDLE;
			end
		endcase
	end

	assign sample_stall = (state_q != rleg_pkg::ST_IDLE);
	assign result_valid = valid_q;

endmodule

`default_nettype wire

/* sv/rleg_dp.sv */
`default_nettype none

module rleg_dp (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire rleg_pkg::cmd_t                cmd,
	input  wire rleg_pkg::sample_t             sample,
	input  wire logic                          loop_mode,
	input  wire logic [rleg_pkg::SP_BITS-1:0]  sample_period,
	output rleg_pkg::status_t                  status,
	output rleg_pkg::result_t                  result
);

	localparam int QB = rleg_pkg::Q_BITS;
	localparam int LB = rleg_pkg::LEVEL_BITS;
	localparam int TB = rleg_pkg::TIME_BITS;
	localparam int PB = rleg_pkg::PROD_BITS;
	localparam int QUB = rleg_pkg::QUO_BITS;

	rleg_pkg::sample_t item_q;
	rleg_pkg::stage_t  stage_q;
	logic signed [QB-1:0] cur_q, start_q;
	logic rising_q, ovf_q;
	logic [QB-1:0]  mag_q;
	logic [TB-1:0]  time_q;
	logic [PB-1:0]  prod_q;
	logic [TB-1:0]  rem_q;
	logic [QUB-1:0] quo_q;
	rleg_pkg::result_t out_q;

	// gate decision and segment evaluation
	logic gate_on, gate_off, active, seg, done, rising;
	rleg_pkg::stage_t st_ent, st_next;
	logic signed [QB-1:0] start_ent, target, level3_q30;
	logic signed [LB-1:0] lvl_sel;
	logic [TB-1:0] time_sel, time_fl;
	logic signed [QB:0] diff;
	logic [QB-1:0] mag;

	always_comb begin
		gate_on  = (item_q.gate_level > rleg_pkg::GATE_HALF);
		gate_off = (item_q.gate_level < rleg_pkg::GATE_HALF);
		active   = (stage_q == rleg_pkg::STG_SEG1) || (stage_q == rleg_pkg::STG_SEG2) ||
			(stage_q == rleg_pkg::STG_SEG3) || (stage_q == rleg_pkg::STG_SUSTAIN);
		st_ent    = stage_q;
		start_ent = start_q;
		if (active) begin
			if (gate_off) begin
				st_ent    = rleg_pkg::STG_RELEASE;
				start_ent = cur_q;
			end
		end else if (gate_on) begin
			st_ent    = rleg_pkg::STG_SEG1;
			start_ent = cur_q;
		end

		seg      = 1'b1;
		lvl_sel  = item_q.level_one;
		time_sel = item_q.time_one;
		st_next  = rleg_pkg::STG_SEG2;
		unique case (st_ent)
			rleg_pkg::STG_SEG1: begin
				lvl_sel  = item_q.level_one;
				time_sel = item_q.time_one;
				st_next  = rleg_pkg::STG_SEG2;
			end
			rleg_pkg::STG_SEG2: begin
				lvl_sel  = item_q.level_two;
				time_sel = item_q.time_two;
				st_next  = rleg_pkg::STG_SEG3;
			end
			rleg_pkg::STG_SEG3: begin
				lvl_sel  = item_q.level_three;
				time_sel = item_q.time_three;
				st_next  = rleg_pkg::STG_SUSTAIN;
			end
			rleg_pkg::STG_RELEASE: begin
				lvl_sel  = item_q.level_four;
				time_sel = item_q.time_four;
				st_next  = rleg_pkg::STG_IDLE;
			end
			default: begin
				seg = 1'b0;
			end
		endcase

		target = $signed({{(QB-LB){lvl_sel[LB-1]}}, lvl_sel}) <<< rleg_pkg::LSHIFT;
		level3_q30 = $signed({{(QB-LB){item_q.level_three[LB-1]}}, item_q.level_three})
			<<< rleg_pkg::LSHIFT;
		diff   = $signed({target[QB-1], target}) - $signed({start_ent[QB-1], start_ent});
		rising = !diff[QB] && (diff != '0);
		// zero slope counts as falling
		done   = rising ? (cur_q >= target) : (cur_q <= target);
		mag    = diff[QB] ? (~diff[QB-1:0] + QB'(1)) : diff[QB-1:0];
		time_fl = (time_sel < rleg_pkg::TIME_FLOOR) ? rleg_pkg::TIME_FLOOR : time_sel;
	end

	assign status.run_div = seg && !done;

	// product of level distance and sample period
	logic [PB-1:0] prod_d;
	assign prod_d = {{(PB-QB){1'b0}}, mag_q} * {{(PB-rleg_pkg::SP_BITS){1'b0}}, sample_period};

	// upper bits set overflow and remainder; bits 39:8 seed the quotient
	logic [TB-1:0] hi_ext;
	assign hi_ext = TB'(prod_q[PB-1:QUB+8]);

	// one restoring divide step
	logic [TB:0] part, trial;
	logic ge;
	always_comb begin
		part  = {rem_q, quo_q[QUB-1]};
		ge    = (part >= {1'b0, time_q});
		trial = part - {1'b0, time_q};
	end

	// level update with saturation to plus or minus one
	logic signed [QB+1:0] sum, step;
	logic signed [QB-1:0] next_level;
	always_comb begin
		step = $signed({2'b00, quo_q});
		sum  = rising_q ? ($signed({{2{cur_q[QB-1]}}, cur_q}) + step) :
			($signed({{2{cur_q[QB-1]}}, cur_q}) - step);
		priority if (ovf_q) begin
			next_level = rising_q ? rleg_pkg::ONE_Q30 : -rleg_pkg::ONE_Q30;
		end else if (sum > $signed({{2{1'b0}}, rleg_pkg::ONE_Q30})) begin
			next_level = rleg_pkg::ONE_Q30;
		end else if (sum < -$signed({{2{1'b0}}, rleg_pkg::ONE_Q30})) begin
			next_level = -rleg_pkg::ONE_Q30;
		end else begin
			next_level = sum[QB-1:0];
		end
	end

	// envelope state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q <= rleg_pkg::STG_IDLE;
			cur_q   <= '0;
			start_q <= '0;
		end else begin
			if (cmd.eval) begin
				unique case (st_ent)
					rleg_pkg::STG_SEG1, rleg_pkg::STG_SEG2, rleg_pkg::STG_SEG3,
					rleg_pkg::STG_RELEASE: begin
						if (done) begin
							start_q <= cur_q;
							stage_q <= st_next;
						end else begin
							start_q <= start_ent;
							stage_q <= st_ent;
						end
					end
					rleg_pkg::STG_SUSTAIN: begin
						if (loop_mode) begin
							start_q <= cur_q;
							stage_q <= rleg_pkg::STG_SEG1;
						end else begin
							start_q <= start_ent;
							stage_q <= st_ent;
							cur_q   <= level3_q30;
						end
					end
					default: begin
						start_q <= start_ent;
						stage_q <= st_ent;
					end
				endcase
			end else if (cmd.apply) begin
				cur_q <= next_level;
			end
		end
	end

	// item capture, multiply, divide and output registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= sample;
		end
		if (cmd.eval) begin
			mag_q    <= mag;
			time_q   <= time_fl;
			rising_q <= rising;
		end
		if (cmd.mul) begin
			prod_q <= prod_d;
		end
		if (cmd.setup) begin
			ovf_q <= (hi_ext >= time_q);
			rem_q <= hi_ext;
			quo_q <= prod_q[QUB+7:8];
		end else if (cmd.div_step) begin
			rem_q <= ge ? trial[TB-1:0] : part[TB-1:0];
			quo_q <= {quo_q[QUB-2:0], ge};
		end
		if (cmd.out_load) begin
			out_q.env_out   <= (cur_q == rleg_pkg::ONE_Q30) ? rleg_pkg::LEVEL_MAXPOS :
				cur_q[rleg_pkg::LSHIFT+LB-1:rleg_pkg::LSHIFT];
			out_q.stage_now <= 3'(stage_q);
		end
	end

	assign result = out_q;

endmodule

`default_nettype wire

/* sv/rate_level_envelope_generator.sv */
`default_nettype none
`include "assert_macros.svh"

// Four-segment rate/level envelope generator: one result per accepted sample.
// An item whose segment is idle, finished or in sustain goes from acceptance to
// result through capture, evaluate and output load; an item whose segment moves
// goes through capture, evaluate, multiply, divider setup, the one-bit-per-cycle
// restoring divider (32 steps) that forms each level step, level update and
// output load. The next sample is taken once the previous one has reached the
// output register, which holds it until the receiver drops result_stall.
// Registers: loop_mode at byte address 0, sample_period at byte address 4.
module rate_level_envelope_generator (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [2:0]           paddr,
	input  wire logic [31:0]          pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	input  wire logic                 sample_valid,
	output logic                      sample_stall,
	input  wire rleg_pkg::sample_t    sample,
	output logic                      result_valid,
	input  wire logic                 result_stall,
	output rleg_pkg::result_t         result
);

	logic loop_mode_q;
	logic [rleg_pkg::SP_BITS-1:0] sample_period_q;
	logic wr_en;

	// configuration registers
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loop_mode_q     <= 1'b0;
			sample_period_q <= rleg_pkg::SAMPLE_PERIOD_RESET;
		end else if (wr_en) begin
			unique case (paddr[2])
				rleg_pkg::REG_LOOP_MODE:     loop_mode_q     <= pwdata[0];
				rleg_pkg::REG_SAMPLE_PERIOD: sample_period_q <= pwdata[rleg_pkg::SP_BITS-1:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (paddr[2])
			rleg_pkg::REG_LOOP_MODE:     prdata = {31'd0, loop_mode_q};
			rleg_pkg::REG_SAMPLE_PERIOD: prdata = {{(32-rleg_pkg::SP_BITS){1'b0}}, sample_period_q};
			default:                     prdata = '0;
		endcase
	end

	rleg_pkg::cmd_t    cmd;
	rleg_pkg::status_t status;

	rleg_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.result_stall (result_stall),
		.status       (status),
		.cmd          (cmd),
		.sample_stall (sample_stall),
		.result_valid (result_valid)
	);

	rleg_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sample        (sample),
		.loop_mode     (loop_mode_q),
		.sample_period (sample_period_q),
		.status        (status),
		.result        (result)
	);

	// checks on the sequencing of items and results
	`RLE_ASSERT_NEXT(a_busy_after_accept, sample_valid && !sample_stall, sample_stall, "sample accepted while idle did not make the block busy")
	`RLE_ASSERT_IMPL(a_stage_code, result_valid, result.stage_now <= 3'(rleg_pkg::STG_RELEASE), "result carries an undefined stage code")
	`RLE_ASSERT_IMPL(a_result_from_item, $rose(result_valid), $past(sample_stall), "result appeared without an item in progress")

endmodule

`default_nettype wire
